// ===== rtl/three_wheel_odometry_unit_defines.svh =====
// Assertion macros shared by the odometry RTL.
`ifndef THREE_WHEEL_ODOMETRY_UNIT_DEFINES_SVH
`define THREE_WHEEL_ODOMETRY_UNIT_DEFINES_SVH
// Implication checked on every clock, disabled in reset.
`define TWO_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define TWO_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

// ===== rtl/two_pkg.sv =====
// Package with types, constants and tables for the odometry unit.
package two_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam int CSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic signed [63:0] PI_Q24 = 64'sd52707179;
    localparam logic signed [63:0] HALF_PI_Q24 = 64'sd26353589;
    localparam logic signed [63:0] TWO_PI_Q24 = 64'sd105414357;
    localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;

    localparam logic [1:0] REG_LEFT = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_BACK = 2'd2;
    localparam logic [1:0] REG_IPT = 2'd3;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] back_count;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] heading;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } out_item_t;

    // Serial multiply, divide and CORDIC request and handshake between units.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DL, ST_DR, ST_DB, ST_DTH, ST_DTHW, ST_CHK,
        ST_CS1, ST_CS1W, ST_MX1, ST_MX1W, ST_DX, ST_DXW,
        ST_MY1, ST_MY1W, ST_DY, ST_DYW, ST_MX2, ST_MX2W, ST_MY2, ST_MY2W,
        ST_LOC, ST_CS2, ST_CS2W, ST_G1, ST_G1W, ST_G2, ST_G2W,
        ST_G3, ST_G3W, ST_G4, ST_G4W, ST_OUT
    } state_t;

    function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
        logic signed [63:0] v;
        unique case (i)
            5'd0: v = 64'sd843314856; 5'd1: v = 64'sd497837829;
            5'd2: v = 64'sd263043836; 5'd3: v = 64'sd133525158;
            5'd4: v = 64'sd67021686;  5'd5: v = 64'sd33543515;
            5'd6: v = 64'sd16775850;  5'd7: v = 64'sd8388437;
            5'd8: v = 64'sd4194282;   5'd9: v = 64'sd2097149;
            5'd10: v = 64'sd1048575;  5'd31: v = 64'sd0;
            default: v = 64'sd1 <<< (5'd30 - i);
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction
endpackage

// ===== rtl/two_mul.sv =====
// Bit-serial signed multiplier, 64 x 64 operands, one bit per cycle.
module two_mul import two_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output unit_ctl_t          ctl,
    output logic signed [63:0] prod
);
    logic [63:0] acc_reg, acc_next, mc_reg, mc_next, mp_reg, mp_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic neg_reg, neg_next;

    always_comb
    begin
        acc_next = acc_reg; mc_next = mc_reg; mp_next = mp_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        neg_next = neg_reg;
        if (start)
        begin
            acc_next = '0;
            mc_next = a[63] ? 64'(-a) : a;
            mp_next = b[63] ? 64'(-b) : b;
            neg_next = a[63] ^ b[63];
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mp_reg[0]) acc_next = acc_reg + mc_reg;
            mc_next = mc_reg << 1;
            mp_next = mp_reg >> 1;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next; mc_reg <= mc_next; mp_reg <= mp_next;
        neg_reg <= neg_next;
    end

    assign prod = neg_reg ? $signed(64'(-acc_reg)) : $signed(acc_reg);
    assign ctl = '{start: start, busy: busy_reg, done: done_reg};
endmodule

// ===== rtl/two_div.sv =====
// Bit-serial signed restoring divider, truncating toward zero.
module two_div import two_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output unit_ctl_t          ctl,
    output logic signed [63:0] quo
);
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [64:0] trial;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next, neg_reg, neg_next;

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg, q_reg[63]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = num[63] ? 64'(-num) : num;
            d_next = den[63] ? 64'(-den) : den;
            r_next = '0;
            neg_next = num[63] ^ den[63];
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; neg_reg <= neg_next;
    end

    assign quo = neg_reg ? $signed(64'(-q_reg)) : $signed(q_reg);
    assign ctl = '{start: start, busy: busy_reg, done: done_reg};
endmodule

// ===== rtl/two_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine in Q30.
module two_cordic import two_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] ang,
    output unit_ctl_t          ctl,
    output logic signed [63:0] sn,
    output logic signed [63:0] cs
);
    `include "three_wheel_odometry_unit_defines.svh"
    logic signed [63:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [63:0] r0, r1, r2, xs, ys;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next, flip_reg, flip_next;
    logic fl;

    // Coarse angle reduction by 21 whole turns; the serial loop below
    // removes the remaining turns one per cycle.
    always_comb
    begin
        r0 = ang;
        if (r0 >= TWO_PI_Q24 * 64'sd21) r0 = r0 - TWO_PI_Q24 * 64'sd21;
        if (r0 <= -TWO_PI_Q24 * 64'sd21) r0 = r0 + TWO_PI_Q24 * 64'sd21;
        r1 = r0;
        r2 = r1;
        fl = 1'b0;
        xs = x_reg >>> cnt_reg[4:0];
        ys = y_reg >>> cnt_reg[4:0];
    end

    logic signed [63:0] red_reg, red_next;
    logic [4:0] rc_reg, rc_next;
    logic red_busy_reg, red_busy_next;

    always_comb
    begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg; flip_next = flip_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        red_next = red_reg; rc_next = rc_reg; red_busy_next = red_busy_reg;
        if (start)
        begin
            red_next = r2;
            rc_next = '0;
            red_busy_next = 1'b1;
            busy_next = 1'b1;
            flip_next = fl;
            cnt_next = '0;
        end
        else if (red_busy_reg)
        begin
            // One subtract or add of 2*pi per cycle brings the angle into range.
            if (red_reg >= TWO_PI_Q24) red_next = red_reg - TWO_PI_Q24;
            else if (red_reg < 64'sd0) red_next = red_reg + TWO_PI_Q24;
            else
            begin
                red_busy_next = 1'b0;
                if (red_reg > PI_Q24) red_next = red_reg - TWO_PI_Q24;
                rc_next = 5'd1;
            end
            if (rc_reg == 5'd1)
            begin
                red_busy_next = 1'b0;
                flip_next = 1'b0;
                if (red_reg > HALF_PI_Q24)
                begin
                    z_next = (red_reg - PI_Q24) <<< 6;
                    flip_next = 1'b1;
                end
                else if (red_reg < -HALF_PI_Q24)
                begin
                    z_next = (red_reg + PI_Q24) <<< 6;
                    flip_next = 1'b1;
                end
                else z_next = red_reg <<< 6;
                x_next = GAIN_Q30;
                y_next = '0;
                cnt_next = '0;
                rc_next = 5'd2;
            end
        end
        else if (busy_reg && rc_reg == 5'd1)
        begin
            rc_next = 5'd1;
            red_busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - atan_q30(cnt_reg[4:0]);
            end
            else
            begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + atan_q30(cnt_reg[4:0]);
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(CSTEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
            red_busy_reg <= 1'b0; rc_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
            red_busy_reg <= red_busy_next; rc_reg <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        flip_reg <= flip_next; red_reg <= red_next;
    end

    assign sn = flip_reg ? $signed(64'(-y_reg)) : y_reg;
    assign cs = flip_reg ? $signed(64'(-x_reg)) : x_reg;
    assign ctl = '{start: start, busy: busy_reg, done: done_reg};

    `TWO_ASSERT_NXT(a_cordic_busy, clk, rst_n, start, busy_reg, "cordic not busy")
    `TWO_ASSERT_IMP(a_cordic_done, clk, rst_n, done_reg, !busy_reg, "done while busy")
    `TWO_ASSERT_IMP(a_cordic_cnt, clk, rst_n, busy_reg && !red_busy_reg,
        cnt_reg < 6'(CSTEPS), "cordic step overrun")
endmodule

// ===== rtl/three_wheel_odometry_unit.sv =====
// Top level of the three-wheel odometry unit.
// Each item is worked through the serial 64-bit multiplier, divider and CORDIC in turn;
// an item without a turn skips the first CORDIC pass and the chord arithmetic after it,
// and each CORDIC pass also removes the whole turns from its angle.
// Throughput: one item at a time; in_ready is high only while idle, and a result not
// yet taken holds the next item in its last state. Reset (rst_n, asynchronous, low)
// clears the pose and the stored counts and loads the default offsets.
module three_wheel_odometry_unit import two_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    `include "three_wheel_odometry_unit_defines.svh"

    state_t state_reg, state_next;
    logic [31:0] lo_reg, ro_reg, bo_reg;
    logic [23:0] ipt_reg;
    logic signed [31:0] ll_reg, lr_reg, lb_reg, ph_reg, px_reg, py_reg;
    logic signed [31:0] ph_next, px_next, py_next;
    in_item_t in_reg;
    // Working registers for one item.
    logic signed [63:0] dl_reg, dr_reg, db_reg, dth_reg, s2_reg;
    logic signed [63:0] lx_reg, ly_reg, t1_reg, t2_reg, cs_reg, sn_reg;
    logic signed [63:0] t1_next, t2_next, cs_next, sn_next;
    logic signed [63:0] dl_next, dr_next, db_next, dth_next, s2_next;
    logic signed [63:0] lx_next, ly_next, half;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic m_start, d_start, c_start;
    logic signed [63:0] m_a, m_b, d_n, d_d, c_ang, prod, quo, csn, ccs;
    unit_ctl_t m_ctl, d_ctl, c_ctl;

    two_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
        .ctl(m_ctl), .prod);
    two_div u_div (.clk, .rst_n, .start(d_start), .num(d_n), .den(d_d),
        .ctl(d_ctl), .quo);
    two_cordic u_cordic (.clk, .rst_n, .start(c_start), .ang(c_ang),
        .ctl(c_ctl), .sn(csn), .cs(ccs));

    logic signed [63:0] den;
    assign den = $signed({32'd0, lo_reg}) + $signed({32'd0, ro_reg});
    assign half = dth_reg >>> 1;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        m_start = 1'b0; d_start = 1'b0; c_start = 1'b0;
        m_a = '0; m_b = '0; d_n = '0; d_d = 64'sd1; c_ang = '0;
        dl_next = dl_reg; dr_next = dr_reg; db_next = db_reg;
        dth_next = dth_reg; s2_next = s2_reg; lx_next = lx_reg; ly_next = ly_reg;
        t1_next = t1_reg; t2_next = t2_reg; cs_next = cs_reg; sn_next = sn_reg;
        ph_next = ph_reg; px_next = px_reg; py_next = py_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DL;
            ST_DL:
            begin
                m_a = 64'(in_reg.left_count) - 64'(ll_reg);
                m_b = {40'd0, ipt_reg}; m_start = !m_ctl.busy && !m_ctl.done;
                if (m_ctl.done)
                begin
                    dl_next = sat32(prod); state_next = ST_DR;
                end
            end
            ST_DR:
            begin
                m_a = 64'(in_reg.right_count) - 64'(lr_reg);
                m_b = {40'd0, ipt_reg}; m_start = !m_ctl.busy && !m_ctl.done;
                if (m_ctl.done)
                begin
                    dr_next = sat32(prod); state_next = ST_DB;
                end
            end
            ST_DB:
            begin
                m_a = 64'(in_reg.back_count) - 64'(lb_reg);
                m_b = {40'd0, ipt_reg}; m_start = !m_ctl.busy && !m_ctl.done;
                if (m_ctl.done)
                begin
                    db_next = sat32(prod); state_next = ST_DTH;
                end
            end
            ST_DTH:
            begin
                if (den == 0)
                begin
                    dth_next = '0; state_next = ST_CHK;
                end
                else
                begin
                    d_n = (dl_reg - dr_reg) <<< 24; d_d = den; d_start = 1'b1;
                    state_next = ST_DTHW;
                end
            end
            ST_DTHW:
            begin
                d_d = den;
                if (d_ctl.done)
                begin
                    dth_next = sat32(quo); state_next = ST_CHK;
                end
            end
            ST_CHK:
                if (dth_reg == 0)
                begin
                    lx_next = db_reg; ly_next = dr_reg; state_next = ST_CS2;
                end
                else state_next = ST_CS1;
            ST_CS1:
            begin
                c_ang = half; c_start = 1'b1; state_next = ST_CS1W;
            end
            ST_CS1W:
                if (c_ctl.done)
                begin
                    s2_next = csn >>> 5; state_next = ST_MX1;
                end
            ST_MX1:
            begin
                m_a = s2_reg; m_b = db_reg; m_start = 1'b1; state_next = ST_MX1W;
            end
            ST_MX1W:
                if (m_ctl.done)
                begin
                    t1_next = prod; state_next = ST_DX;
                end
            ST_DX:
            begin
                d_n = t1_reg; d_d = dth_reg; d_start = 1'b1; state_next = ST_DXW;
            end
            ST_DXW:
            begin
                d_d = dth_reg;
                if (d_ctl.done)
                begin
                    lx_next = quo; state_next = ST_MY1;
                end
            end
            ST_MY1:
            begin
                m_a = s2_reg; m_b = dr_reg; m_start = 1'b1; state_next = ST_MY1W;
            end
            ST_MY1W:
                if (m_ctl.done)
                begin
                    t1_next = prod; state_next = ST_DY;
                end
            ST_DY:
            begin
                d_n = t1_reg; d_d = dth_reg; d_start = 1'b1; state_next = ST_DYW;
            end
            ST_DYW:
            begin
                d_d = dth_reg;
                if (d_ctl.done)
                begin
                    ly_next = quo; state_next = ST_MX2;
                end
            end
            ST_MX2:
            begin
                m_a = s2_reg; m_b = {32'd0, bo_reg}; m_start = 1'b1;
                state_next = ST_MX2W;
            end
            ST_MX2W:
                if (m_ctl.done)
                begin
                    t1_next = prod >>> 24; state_next = ST_MY2;
                end
            ST_MY2:
            begin
                m_a = s2_reg; m_b = {32'd0, ro_reg}; m_start = 1'b1;
                state_next = ST_MY2W;
            end
            ST_MY2W:
                if (m_ctl.done)
                begin
                    t2_next = prod >>> 24; state_next = ST_LOC;
                end
            ST_LOC:
            begin
                lx_next = sat32(lx_reg + t1_reg); ly_next = sat32(ly_reg + t2_reg);
                state_next = ST_CS2;
            end
            ST_CS2:
            begin
                c_ang = 64'(ph_reg) + half; c_start = 1'b1; state_next = ST_CS2W;
            end
            ST_CS2W:
                if (c_ctl.done)
                begin
                    cs_next = ccs; sn_next = csn; state_next = ST_G1;
                end
            ST_G1:
            begin
                m_a = lx_reg; m_b = cs_reg; m_start = 1'b1; state_next = ST_G1W;
            end
            ST_G1W:
                if (m_ctl.done)
                begin
                    t1_next = prod; state_next = ST_G2;
                end
            ST_G2:
            begin
                m_a = ly_reg; m_b = sn_reg; m_start = 1'b1; state_next = ST_G2W;
            end
            ST_G2W:
                if (m_ctl.done)
                begin
                    px_next = 32'(sat32(64'(px_reg) + ((t1_reg + prod) >>> 38)));
                    state_next = ST_G3;
                end
            ST_G3:
            begin
                m_a = ly_reg; m_b = cs_reg; m_start = 1'b1; state_next = ST_G3W;
            end
            ST_G3W:
                if (m_ctl.done)
                begin
                    t1_next = prod; state_next = ST_G4;
                end
            ST_G4:
            begin
                m_a = lx_reg; m_b = sn_reg; m_start = 1'b1; state_next = ST_G4W;
            end
            ST_G4W:
                if (m_ctl.done)
                begin
                    py_next = 32'(sat32(64'(py_reg) + ((t1_reg - prod) >>> 38)));
                    ph_next = 32'(sat32(64'(ph_reg) + dth_reg));
                    state_next = ST_OUT;
                end
            ST_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{heading: ph_reg, pos_x: px_reg, pos_y: py_reg};
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lo_reg <= 32'd52428800; ro_reg <= 32'd52428800;
            bo_reg <= 32'd94371840; ipt_reg <= 24'd402653;
            ll_reg <= '0; lr_reg <= '0; lb_reg <= '0;
            ph_reg <= '0; px_reg <= '0; py_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            ph_reg <= ph_next; px_reg <= px_next; py_reg <= py_next;
            if (state_reg == ST_DTH)
            begin
                ll_reg <= in_reg.left_count; lr_reg <= in_reg.right_count;
                lb_reg <= in_reg.back_count;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEFT: lo_reg <= cfg_data;
                    REG_RIGHT: ro_reg <= cfg_data;
                    REG_BACK: bo_reg <= cfg_data;
                    REG_IPT: ipt_reg <= cfg_data[23:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) in_reg <= in_data;
        dl_reg <= dl_next; dr_reg <= dr_next; db_reg <= db_next;
        dth_reg <= dth_next; s2_reg <= s2_next; lx_reg <= lx_next; ly_reg <= ly_next;
        t1_reg <= t1_next; t2_reg <= t2_next; cs_reg <= cs_next; sn_reg <= sn_next;
        out_reg <= out_next;
    end

    `TWO_ASSERT_IMP(a_one_unit, clk, rst_n, 1'b1,
        !(m_ctl.busy && d_ctl.busy), "multiplier and divider overlap")
    `TWO_ASSERT_NXT(a_accept, clk, rst_n, in_valid && in_ready, state_reg == ST_DL,
        "accept did not start item")
    `TWO_ASSERT_IMP(a_out_hold, clk, rst_n, state_reg == ST_IDLE && !in_valid,
        !m_ctl.busy, "unit busy while idle")
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the three-wheel odometry unit.
`timescale 1ns / 100ps

module testbench;
    import two_pkg::*;

    // Traffic shapes for the two handshakes.
    typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

    // One row of the directed table.  When typed is set, the pose in want
    // is the result read straight off the arithmetic; otherwise the pose
    // predictor supplies it.
    typedef struct {
        in_item_t  counts;
        bit        typed;
        out_item_t want;
    } sample_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Predictor copy of the registers and of the pose state.
    longint      p_left_off;
    longint      p_right_off;
    longint      p_back_off;
    longint      p_ipt;
    longint      p_last_l;
    longint      p_last_r;
    longint      p_last_b;
    longint      p_heading;
    longint      p_x;
    longint      p_y;

    out_item_t   pose_expect_q[$];
    int          errors;
    idle_mode_t  idle_mode;
    bit          hold_req;
    bit          hold_rx;

    // Walking encoder counts used to build smooth motion in the random part.
    int          walk_l;
    int          walk_r;
    int          walk_b;

    three_wheel_odometry_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Arctangent table in Q30 for the CORDIC rotation.
    function automatic longint arctan_q30(int i);
        longint tab[11] = '{843314856, 497837829, 263043836, 133525158,
                            67021686, 33543515, 16775850, 8388437,
                            4194282, 2097149, 1048575};
        if (i < 11)
            return tab[i];
        if (i >= 31)
            return 0;
        return longint'(1) <<< (30 - i);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Sine and cosine in Q30 of an angle in Q8.24.  The angle is folded
    // into [-pi/2, pi/2] first, with a sign flip on the result.
    task automatic rotate_sincos(input longint ang, output longint sn, output longint cs);
        longint r;
        longint x;
        longint y;
        longint z;
        longint t;
        bit     flip;
        r = ang % TWO_PI_Q24;
        flip = 1'b0;
        x = GAIN_Q30;
        y = 0;
        if (r < 0)
            r += TWO_PI_Q24;
        if (r > PI_Q24)
            r -= TWO_PI_Q24;
        if (r > HALF_PI_Q24)
        begin
            r -= PI_Q24;
            flip = 1'b1;
        end
        else if (r < -HALF_PI_Q24)
        begin
            r += PI_Q24;
            flip = 1'b1;
        end
        z = r * 64;
        for (int i = 0; i < CSTEPS; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_q30(i);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_q30(i);
            end
            x = t;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // Advance the predicted pose by one encoder sample and return it.
    task automatic advance_pose(input in_item_t s, output out_item_t pose);
        longint dl;
        longint dr;
        longint db;
        longint den;
        longint dth;
        longint half;
        longint lx;
        longint ly;
        longint sn;
        longint cs;
        longint s2;
        longint gx;
        longint gy;
        dl = clamp32((longint'(s.left_count) - p_last_l) * p_ipt);
        dr = clamp32((longint'(s.right_count) - p_last_r) * p_ipt);
        db = clamp32((longint'(s.back_count) - p_last_b) * p_ipt);
        den = p_left_off + p_right_off;
        p_last_l = longint'(s.left_count);
        p_last_r = longint'(s.right_count);
        p_last_b = longint'(s.back_count);
        dth = 0;
        if (den != 0)
            dth = clamp32(((dl - dr) * 64'sd16777216) / den);
        half = dth >>> 1;
        if (dth == 0)
        begin
            lx = db;
            ly = dr;
        end
        else
        begin
            rotate_sincos(half, sn, cs);
            s2 = sn >>> 5;
            lx = clamp32((s2 * db) / dth + ((s2 * p_back_off) >>> 24));
            ly = clamp32((s2 * dr) / dth + ((s2 * p_right_off) >>> 24));
        end
        rotate_sincos(p_heading + half, sn, cs);
        gx = lx * cs + ly * sn;
        gy = ly * cs - lx * sn;
        p_x = clamp32(p_x + (gx >>> 38));
        p_y = clamp32(p_y + (gy >>> 38));
        p_heading = clamp32(p_heading + dth);
        pose.heading = p_heading[31:0];
        pose.pos_x = p_x[31:0];
        pose.pos_y = p_y[31:0];
    endtask

    // Register write; only called while the block is idle.  The write
    // enable drops again before the task returns.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEFT:  p_left_off = longint'(val);
            REG_RIGHT: p_right_off = longint'(val);
            REG_BACK:  p_back_off = longint'(val);
            REG_IPT:   p_ipt = longint'(val[23:0]);
            default:   ;
        endcase
        @(posedge clk);
    endtask

    // Offer one sample and hold it until the block takes it.  Called right
    // after a rising edge.  Acceptance is seen at the falling edge, where
    // valid and ready are stable up to the next rising edge.
    task automatic offer_sample(input in_item_t s, input bit typed, input out_item_t want);
        out_item_t pose;
        in_valid <= 1'b1;
        in_data <= s;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        advance_pose(s, pose);
        pose_expect_q.push_back(typed ? want : pose);
        @(posedge clk);
        // Random gap, or keep valid high straight into the next item.
        if (idle_mode != IDLE_NONE)
        begin
            int pct;
            pct = (idle_mode == IDLE_SEND_LIGHT) ? 27 : 80;
            while ($urandom_range(99) < pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Let the block drain completely before touching the registers.
    task automatic drain();
        in_valid <= 1'b0;
        while (pose_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly smooth motion from the walking counts, with some wild jumps
    // that drive every bit of the count fields.
    function automatic in_item_t random_sample();
        in_item_t s;
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
        begin
            walk_l += int'($urandom_range(4000)) - 2000;
            walk_r += int'($urandom_range(4000)) - 2000;
            walk_b += int'($urandom_range(1000)) - 500;
        end
        else if (sel < 92)
        begin
            // Straight drive: both side wheels move alike, so no turn.
            int d;
            d = int'($urandom_range(6000)) - 3000;
            walk_l += d;
            walk_r += d;
            walk_b += int'($urandom_range(20)) - 10;
        end
        else
        begin
            walk_l = $urandom;
            walk_r = $urandom;
            walk_b = $urandom;
        end
        s.left_count = walk_l;
        s.right_count = walk_r;
        s.back_count = walk_b;
        return s;
    endfunction

    task automatic run_random(input int n);
        out_item_t none;
        none = '0;
        for (int i = 0; i < n; i++)
            offer_sample(random_sample(), 1'b0, none);
    endtask

    // Receiver: random stalls per mode, plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_rx)
            out_ready <= 1'b0;
        else if (idle_mode == IDLE_SEND_LIGHT)
            out_ready <= ($urandom_range(99) >= 80);
        else if (idle_mode == IDLE_SEND_HEAVY)
            out_ready <= ($urandom_range(99) >= 27);
        else
            out_ready <= 1'b1;
    end

    // The long hold-off is counted here so that the sender keeps offering
    // items while the block holds an untaken result and stalls the next one.
    initial
    begin
        hold_rx = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (4000) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Check each result as it is taken against the oldest expected pose.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result heading=%h x=%h y=%h", $time,
                         out_data.heading, out_data.pos_x, out_data.pos_y);
                errors++;
            end
            else
            begin
                out_item_t want;
                want = pose_expect_q.pop_front();
                if (out_data.heading !== want.heading)
                begin
                    $display("%0t: heading expected %h actual %h", $time,
                             want.heading, out_data.heading);
                    errors++;
                end
                if (out_data.pos_x !== want.pos_x)
                begin
                    $display("%0t: pos_x expected %h actual %h", $time,
                             want.pos_x, out_data.pos_x);
                    errors++;
                end
                if (out_data.pos_y !== want.pos_y)
                begin
                    $display("%0t: pos_y expected %h actual %h", $time,
                             want.pos_y, out_data.pos_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        sample_row_t rows[$];
        sample_row_t row;
        int          waited;

        errors = 0;
        hold_req = 1'b0;
        idle_mode = IDLE_SEND_LIGHT;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LEFT;
        cfg_data = '0;
        walk_l = 0;
        walk_r = 0;
        walk_b = 0;

        // Register defaults and a zero pose after reset.
        p_left_off = 52428800;
        p_right_off = 52428800;
        p_back_off = 94371840;
        p_ipt = 402653;
        p_last_l = 0;
        p_last_r = 0;
        p_last_b = 0;
        p_heading = 0;
        p_x = 0;
        p_y = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.  The first sample is measured from count zero, so
        // an all-zero sample leaves the pose at zero; so does repeating it.
        row.typed = 1'b1;
        row.want = '0;
        row.counts = '{0, 0, 0};
        rows.push_back(row);
        rows.push_back(row);
        row.typed = 1'b0;
        // Straight drive: equal side wheels give no turn.
        row.counts = '{1000, 1000, 0};
        rows.push_back(row);
        // Sideways slide on the back wheel only.
        row.counts = '{1000, 1000, 800};
        rows.push_back(row);
        // Turns both ways.
        row.counts = '{1500, 900, 800};
        rows.push_back(row);
        row.counts = '{1200, 1800, 700};
        rows.push_back(row);
        // Count extremes: the distances saturate.
        row.counts = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        rows.push_back(row);
        row.counts = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        rows.push_back(row);
        row.counts = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
        rows.push_back(row);
        row.counts = '{-1, 0, -1};
        rows.push_back(row);
        // Repeated large turns to push the heading toward saturation.
        for (int i = 0; i < 6; i++)
        begin
            if (i % 2)
                row.counts = '{32'sh7fffffff, 32'sh80000000, 0};
            else
                row.counts = '{32'sh80000000, 32'sh7fffffff, 0};
            rows.push_back(row);
        end
        foreach (rows[i])
            offer_sample(rows[i].counts, rows[i].typed, rows[i].want);
        drain();

        // Start the random part from a known count origin again.
        walk_l = int'(p_last_l);
        walk_r = int'(p_last_r);
        walk_b = int'(p_last_b);

        // Default registers, sender idles little and receiver much.
        idle_mode = IDLE_SEND_LIGHT;
        run_random(250);

        // Now the other way round, with the long receiver hold-off.
        idle_mode = IDLE_SEND_HEAVY;
        hold_req = 1'b1;
        run_random(250);
        drain();

        // Register sweep, extremes included.
        idle_mode = IDLE_NONE;
        write_reg(REG_LEFT, 32'd0);
        write_reg(REG_RIGHT, 32'd0);
        write_reg(REG_BACK, 32'd0);
        write_reg(REG_IPT, 32'h00ffffff);
        run_random(150);
        drain();

        idle_mode = IDLE_SEND_LIGHT;
        write_reg(REG_LEFT, 32'hffffffff);
        write_reg(REG_RIGHT, 32'hffffffff);
        write_reg(REG_BACK, 32'hffffffff);
        write_reg(REG_IPT, 32'd0);
        run_random(100);
        drain();

        idle_mode = IDLE_SEND_HEAVY;
        write_reg(REG_IPT, 32'd1);
        write_reg(REG_LEFT, 32'd1);
        write_reg(REG_RIGHT, 32'd0);
        run_random(150);
        drain();

        // Random register values between phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = idle_mode_t'(ph % 3);
            write_reg(REG_LEFT, $urandom);
            write_reg(REG_RIGHT, $urandom);
            write_reg(REG_BACK, $urandom);
            write_reg(REG_IPT, $urandom);
            run_random(100);
            drain();
        end

        // Back to a realistic robot geometry with no idling at all.
        idle_mode = IDLE_NONE;
        write_reg(REG_LEFT, 32'd52428800);
        write_reg(REG_RIGHT, 32'd52428800);
        write_reg(REG_BACK, 32'd94371840);
        write_reg(REG_IPT, 32'd402653);
        run_random(300);

        in_valid <= 1'b0;
        waited = 0;
        while (pose_expect_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (1000) @(posedge clk);
        if (errors == 0 && pose_expect_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            if (pose_expect_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         pose_expect_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
